// ===== rtl/wbs_pkg.sv =====
// ============================================================================
// wbs_pkg
// Shared types, constants and saturation helper for the band smoother.
// ============================================================================
package wbs_pkg;

    localparam int D_W        = 48;
    localparam int FRAC_W     = 24;
    localparam int SAMPLE_W   = 24;
    localparam int WEIGHT_W   = 16;
    localparam int POS_W      = 6;
    localparam int COEF_W     = 16;
    localparam int ORDER_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ORDER      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_LAMBDA = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF0      = 3'd2;

    localparam logic signed [D_W-1:0] LIM_POS = {1'b0, {(D_W-1){1'b1}}};
    localparam logic signed [D_W-1:0] LIM_NEG = {1'b1, {(D_W-1){1'b0}}};

    typedef struct packed {
        logic        [WEIGHT_W-1:0] weight;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_item;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] smoothed_value;
        logic        [POS_W-1:0]    position;
        logic                       last_result;
        logic                       pivot_error;
    } t_out_item;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_B_RD, ST_B_INIT, ST_B_K,
        ST_F_J, ST_F_J1, ST_F_KCHK, ST_F_K0, ST_F_K1, ST_F_K2, ST_F_K3,
        ST_F_K4, ST_F_K5, ST_F_K6, ST_F_END, ST_F_DIV, ST_F_JNXT,
        ST_V_RD, ST_V_MUL, ST_V_MW, ST_V_CHK, ST_V_R, ST_V_R1, ST_V_W,
        ST_K_RD, ST_K_DIV, ST_K_DW, ST_K_CHK, ST_K_R, ST_K_R1, ST_K_W,
        ST_O_RD, ST_O_OUT
    } t_state;

    function automatic logic signed [COEF_W-1:0] f_coef_reset(input int c);
        logic signed [COEF_W-1:0] v;
        case (c)
            0:       v = 16'sd256;
            1:       v = -16'sd512;
            2:       v = 16'sd256;
            default: v = '0;
        endcase
        return v;
    endfunction

    // magnitude plus sign to saturated signed Q24.24
    function automatic logic signed [D_W-1:0] f_signed_sat(input logic [D_W+1:0] m,
                                                           input logic neg,
                                                           input logic ovf);
        logic big;
        logic signed [D_W-1:0] v;
        big = ovf || (m[D_W+1:D_W-1] != '0);
        if (neg) begin
            v = big ? LIM_NEG : -$signed(m[D_W-1:0]);
        end else begin
            v = big ? LIM_POS : $signed(m[D_W-1:0]);
        end
        return v;
    endfunction

endpackage

// ===== rtl/wbs_ram.sv =====
// ============================================================================
// wbs_ram
// Simple dual-port RAM, one write and one registered read port.
// ============================================================================
module wbs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/wbs_mul.sv =====
// ============================================================================
// wbs_mul
// Saturating Q24.24 multiplier, four 24x24 partial products, one per cycle.
// ============================================================================
module wbs_mul (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [wbs_pkg::D_W-1:0]  i_a,
    input  logic signed [wbs_pkg::D_W-1:0]  i_b,
    output logic                            o_done,
    output logic signed [wbs_pkg::D_W-1:0]  o_p
);

    localparam int DW = wbs_pkg::D_W;
    localparam int FW = wbs_pkg::FRAC_W;

    logic          r_run;
    logic [2:0]    r_cnt;
    logic [DW-1:0] r_ma;
    logic [DW-1:0] r_mb;
    logic          r_neg;
    logic          r_ovf;
    logic [DW-1:0] r_prod;
    logic [DW+1:0] r_acc;
    logic [FW-1:0] s_x;
    logic [FW-1:0] s_y;

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    begin s_x = r_ma[DW-1:FW]; s_y = r_mb[DW-1:FW]; end
            2'd1:    begin s_x = r_ma[DW-1:FW]; s_y = r_mb[FW-1:0];  end
            2'd2:    begin s_x = r_ma[FW-1:0];  s_y = r_mb[DW-1:FW]; end
            default: begin s_x = r_ma[FW-1:0];  s_y = r_mb[FW-1:0];  end
        endcase
    end

    assign o_done = r_run && (r_cnt == 3'd5);
    assign o_p    = wbs_pkg::f_signed_sat(r_acc, r_neg, r_ovf);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_cnt <= '0;
            r_ma  <= i_a[DW-1] ? DW'(-i_a) : DW'(i_a);
            r_mb  <= i_b[DW-1] ? DW'(-i_b) : DW'(i_b);
            r_neg <= i_a[DW-1] ^ i_b[DW-1];
            r_ovf <= 1'b0;
            r_acc <= '0;
        end else if (r_run) begin
            if (r_cnt < 3'd4) begin
                r_prod <= DW'(s_x) * DW'(s_y);
            end
            case (r_cnt)
                3'd1: begin
                    r_ovf <= (r_prod[DW-1:FW] != '0);
                    r_acc <= {2'b00, r_prod[FW-1:0], {FW{1'b0}}};
                end
                3'd2, 3'd3: r_acc <= r_acc + {2'b00, r_prod};
                3'd4:       r_acc <= r_acc + {{(FW+2){1'b0}}, r_prod[DW-1:FW]};
                default:    r_acc <= r_acc;
            endcase
            if (r_cnt == 3'd5) begin
                r_run <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

endmodule

// ===== rtl/wbs_div.sv =====
// ============================================================================
// wbs_div
// Saturating Q24.24 divider, restoring, one quotient bit per cycle.
// ============================================================================
module wbs_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [wbs_pkg::D_W-1:0]  i_n,
    input  logic signed [wbs_pkg::D_W-1:0]  i_d,
    output logic                            o_done,
    output logic signed [wbs_pkg::D_W-1:0]  o_q
);

    localparam int DW    = wbs_pkg::D_W;
    localparam int FW    = wbs_pkg::FRAC_W;
    localparam int QW    = DW + FW;
    localparam int CNT_W = $clog2(QW + 1);

    logic             r_run;
    logic [CNT_W-1:0] r_cnt;
    logic [QW-1:0]    r_dvd;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_md;
    logic             r_neg;
    logic             r_dz;
    logic [DW:0]      s_t;
    logic             s_ge;

    assign s_t  = {r_rem, r_dvd[QW-1]};
    assign s_ge = (s_t >= {1'b0, r_md});

    assign o_done = r_run && (r_cnt == CNT_W'(QW));
    assign o_q    = r_dz ? '0 : wbs_pkg::f_signed_sat({2'b00, r_dvd[DW-1:0]}, r_neg,
                                                     (r_dvd[QW-1:DW] != '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_cnt <= '0;
            r_dvd <= {(i_n[DW-1] ? DW'(-i_n) : DW'(i_n)), {FW{1'b0}}};
            r_rem <= '0;
            r_md  <= i_d[DW-1] ? DW'(-i_d) : DW'(i_d);
            r_neg <= i_n[DW-1] ^ i_d[DW-1];
            r_dz  <= (i_d == '0);
        end else if (r_run) begin
            if (r_cnt == CNT_W'(QW)) begin
                r_run <= 1'b0;
            end else begin
                r_rem <= s_ge ? DW'(s_t - {1'b0, r_md}) : s_t[DW-1:0];
                r_dvd <= {r_dvd[QW-2:0], s_ge};
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/whittaker_band_smoother_top.sv =====
// ============================================================================
// whittaker_band_smoother_top
// Whittaker smoother: band LDL factor and solve over stored samples.
// ============================================================================
// Input: pulse start with i_in while busy is low; each transfer stores one
// weighted sample. Samples past MAX_LENGTH are dropped. The transfer with
// last_item set raises busy and starts the run on the stored series.
// Output: one transfer per position, o_strobe high for one cycle, positions
// in order, last_result on the final one. The receiver cannot stall; each
// result is strobed after its read from the solution RAM during readout.
// Run: loading stores one item per cycle. The run is serial on one shared
// multiplier and one divider, with registered band RAM reads. busy drops
// after the last result. Configuration is to be written by the user only
// while busy is low; the block itself does not enforce this.
// Reset: configuration registers return to defaults, the state, item count
// and error flag clear; RAM contents are left as they are and are only read
// after being written.
// ============================================================================
module whittaker_band_smoother_top #(
    parameter int MAX_LENGTH = 64,
    parameter int MAX_ORDER  = 5
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  wbs_pkg::t_in_item                   i_in,
    output logic                                o_strobe,
    output wbs_pkg::t_out_item                  o_result,
    input  logic                                i_cfg_we,
    input  logic [wbs_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [wbs_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int DW    = wbs_pkg::D_W;
    localparam int FW    = wbs_pkg::FRAC_W;
    localparam int SW    = wbs_pkg::SAMPLE_W;
    localparam int WW    = wbs_pkg::WEIGHT_W;
    localparam int CFW   = wbs_pkg::COEF_W;
    localparam int OW    = wbs_pkg::ORDER_W;
    localparam int PW    = wbs_pkg::POS_W;
    localparam int CIW   = wbs_pkg::CFG_IDX_W;
    localparam int IW    = $clog2(MAX_LENGTH + MAX_ORDER + 2);
    localparam int AW    = $clog2(MAX_LENGTH);
    localparam int CW    = (MAX_ORDER > 0) ? $clog2(MAX_ORDER + 1) : 1;
    localparam int BD    = MAX_LENGTH * (MAX_ORDER + 1);
    localparam int BAW   = $clog2(BD);

    localparam logic [IW-1:0]  ONE    = IW'(1);
    localparam logic [IW-1:0]  MAXO   = IW'(MAX_ORDER);
    localparam logic [IW-1:0]  MAXL   = IW'(MAX_LENGTH);
    localparam logic [BAW-1:0] ROWSZ  = BAW'(MAX_ORDER + 1);
    localparam logic [CIW-1:0] CO_LST = CIW'(MAX_ORDER);

    wbs_pkg::t_state r_state, n_state;

    logic [OW-1:0]           r_order;
    logic [31:0]             r_inv;
    logic signed [CFW-1:0]   r_coef [MAX_ORDER+1];

    logic [IW-1:0] r_cnt, n_cnt;
    logic [IW-1:0] r_m, n_m;
    logic [IW-1:0] r_n, n_n;
    logic [IW-1:0] r_i, n_i;
    logic [IW-1:0] r_j, n_j;
    logic [IW-1:0] r_k, n_k;
    logic signed [DW-1:0] r_s, n_s;
    logic signed [DW-1:0] r_t, n_t;
    logic signed [DW-1:0] r_d, n_d;
    logic signed [DW-1:0] r_l1, n_l1;
    logic signed [DW-1:0] r_l2, n_l2;
    logic r_err, n_err;

    logic           ws_we;
    logic [AW-1:0]  ws_waddr, ws_raddr;
    logic [WW-1:0]  w_rdata;
    logic [SW-1:0]  smp_rdata;
    logic           band_we;
    logic [BAW-1:0] band_waddr, band_raddr;
    logic [DW-1:0]  band_wdata, band_rdata;
    logic           sol_we;
    logic [AW-1:0]  sol_waddr, sol_raddr;
    logic [DW-1:0]  sol_wdata, sol_rdata;

    logic                 mul_start, mul_done;
    logic signed [DW-1:0] mul_a, mul_b, mul_p;
    logic                 div_start, div_done;
    logic signed [DW-1:0] div_n, div_d, div_q;

    logic [IW-1:0] s_kf1, s_vj1, s_j2, s_jb2, s_ik;

    function automatic logic [AW-1:0] f_row(input logic [IW-1:0] x);
        logic [IW-1:0] t;
        t = x - ONE;
        return t[AW-1:0];
    endfunction

    function automatic logic [BAW-1:0] f_baddr(input logic [IW-1:0] row1,
                                               input logic [IW-1:0] col);
        logic [IW-1:0] t;
        t = row1 - ONE;
        return BAW'(t[AW-1:0]) * ROWSZ + BAW'(col[CW-1:0]);
    endfunction

    function automatic logic signed [DW-1:0] f_sat_add(input logic signed [DW-1:0] a,
                                                       input logic signed [DW-1:0] b);
        logic signed [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1]) begin
            return s[DW] ? wbs_pkg::LIM_NEG : wbs_pkg::LIM_POS;
        end
        return s[DW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] f_sat_sub(input logic signed [DW-1:0] a,
                                                       input logic signed [DW-1:0] b);
        logic signed [DW:0] s;
        s = {a[DW-1], a} - {b[DW-1], b};
        if (s[DW] != s[DW-1]) begin
            return s[DW] ? wbs_pkg::LIM_NEG : wbs_pkg::LIM_POS;
        end
        return s[DW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] f_wl(input logic [WW-1:0] w,
                                                  input logic [31:0] inv);
        logic [DW-1:0] p;
        p = DW'(w) * DW'(inv);
        return p[DW-1] ? wbs_pkg::LIM_POS : $signed(p);
    endfunction

    function automatic logic signed [SW-1:0] f_out(input logic signed [DW-1:0] v);
        logic signed [DW:0] t;
        logic signed [SW:0] q;
        t = {v[DW-1], v} + (DW+1)'(1 << (FW - 1));
        q = t[DW:FW];
        if (!q[SW] && q[SW-1]) begin
            return {1'b0, {(SW-1){1'b1}}};
        end
        if (q[SW] && !q[SW-1]) begin
            return {1'b1, {(SW-1){1'b0}}};
        end
        return q[SW-1:0];
    endfunction

    // ---- storage ----
    wbs_ram #(.WIDTH(WW), .DEPTH(MAX_LENGTH)) u_weight_ram (
        .i_clk(i_clk), .i_we(ws_we), .i_waddr(ws_waddr), .i_wdata(i_in.weight),
        .i_raddr(ws_raddr), .o_rdata(w_rdata)
    );

    wbs_ram #(.WIDTH(SW), .DEPTH(MAX_LENGTH)) u_sample_ram (
        .i_clk(i_clk), .i_we(ws_we), .i_waddr(ws_waddr), .i_wdata(i_in.sample),
        .i_raddr(ws_raddr), .o_rdata(smp_rdata)
    );

    wbs_ram #(.WIDTH(DW), .DEPTH(BD)) u_band_ram (
        .i_clk(i_clk), .i_we(band_we), .i_waddr(band_waddr), .i_wdata(band_wdata),
        .i_raddr(band_raddr), .o_rdata(band_rdata)
    );

    wbs_ram #(.WIDTH(DW), .DEPTH(MAX_LENGTH)) u_sol_ram (
        .i_clk(i_clk), .i_we(sol_we), .i_waddr(sol_waddr), .i_wdata(sol_wdata),
        .i_raddr(sol_raddr), .o_rdata(sol_rdata)
    );

    wbs_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start),
        .i_a(mul_a), .i_b(mul_b), .o_done(mul_done), .o_p(mul_p)
    );

    wbs_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_n(div_n), .i_d(div_d), .o_done(div_done), .o_q(div_q)
    );

    // ---- configuration ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= OW'(2);
            r_inv   <= 32'd65536;
            for (int c = 0; c <= MAX_ORDER; c++) begin
                r_coef[c] <= wbs_pkg::f_coef_reset(c);
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wbs_pkg::REG_ORDER:      r_order <= i_cfg_data[OW-1:0];
                wbs_pkg::REG_INV_LAMBDA: r_inv   <= i_cfg_data;
                default: begin
                    if (i_cfg_idx >= wbs_pkg::REG_COEF0 &&
                        (i_cfg_idx - wbs_pkg::REG_COEF0) <= CO_LST) begin
                        r_coef[CW'(i_cfg_idx - wbs_pkg::REG_COEF0)] <= i_cfg_data[CFW-1:0];
                    end
                end
            endcase
        end
    end

    // ---- loop bounds ----
    assign s_kf1 = (r_j > r_n) ? r_j - r_n : ONE;
    assign s_vj1 = (r_i > r_n) ? r_i - r_n : ONE;
    assign s_j2  = (r_i + r_n > r_m) ? r_m : r_i + r_n;
    assign s_jb2 = (r_m - r_i < r_n) ? r_m - r_i : r_n;
    assign s_ik  = r_i + r_k;

    assign busy = (r_state != wbs_pkg::ST_IDLE);

    // ---- sequencer ----
    always_comb begin
        logic signed [31:0] cp;
        n_state = r_state;
        n_cnt = r_cnt;  n_m = r_m;  n_n = r_n;
        n_i = r_i;      n_j = r_j;  n_k = r_k;
        n_s = r_s;      n_t = r_t;  n_d = r_d;
        n_l1 = r_l1;    n_l2 = r_l2;
        n_err = r_err;
        ws_we = 1'b0;   ws_waddr = r_cnt[AW-1:0];  ws_raddr = f_row(r_i);
        band_we = 1'b0; band_waddr = f_baddr(r_i, r_j - r_i); band_wdata = r_t;
        band_raddr = '0;
        sol_we = 1'b0;  sol_waddr = f_row(r_i);    sol_wdata = r_s;  sol_raddr = '0;
        mul_start = 1'b0; mul_a = r_d; mul_b = r_l1;
        div_start = 1'b0; div_n = r_t; div_d = r_s;
        o_strobe = 1'b0;
        o_result = '0;
        cp = r_coef[r_k[CW-1:0]] * r_coef[CW'(r_k - r_j)];

        case (r_state)
            wbs_pkg::ST_IDLE: begin
                if (start) begin
                    if (r_cnt < MAXL) begin
                        ws_we = 1'b1;
                        n_cnt = r_cnt + ONE;
                    end
                    if (i_in.last_item) begin
                        n_m   = (r_cnt < MAXL) ? r_cnt + ONE : r_cnt;
                        n_n   = (IW'(r_order) > MAXO) ? MAXO : IW'(r_order);
                        n_i   = ONE;
                        n_j   = '0;
                        n_err = 1'b0;
                        n_state = wbs_pkg::ST_B_RD;
                    end
                end
            end

            // band matrix build
            wbs_pkg::ST_B_RD: begin
                n_state = wbs_pkg::ST_B_INIT;
            end
            wbs_pkg::ST_B_INIT: begin
                n_s = (r_j == '0) ? f_wl(w_rdata, r_inv) : '0;
                n_k = r_j;
                n_state = wbs_pkg::ST_B_K;
            end
            wbs_pkg::ST_B_K: begin
                if (r_k <= r_n) begin
                    if (s_ik > r_n && s_ik <= r_m) begin
                        n_s = f_sat_add(r_s, {{8{cp[31]}}, cp, 8'b0});
                    end
                    n_k = r_k + ONE;
                end else begin
                    band_we    = 1'b1;
                    band_waddr = f_baddr(r_i, r_j);
                    band_wdata = r_s;
                    if (r_j < s_jb2) begin
                        n_j = r_j + ONE;
                        n_state = wbs_pkg::ST_B_RD;
                    end else if (r_i < r_m) begin
                        n_i = r_i + ONE;
                        n_j = '0;
                        n_state = wbs_pkg::ST_B_RD;
                    end else begin
                        n_i = ONE;
                        n_j = ONE;
                        n_state = wbs_pkg::ST_F_J;
                    end
                end
            end

            // band LDL factorization
            wbs_pkg::ST_F_J: begin
                band_raddr = f_baddr(r_i, r_j - r_i);
                n_state = wbs_pkg::ST_F_J1;
            end
            wbs_pkg::ST_F_J1: begin
                n_t = band_rdata;
                n_k = s_kf1;
                n_state = wbs_pkg::ST_F_KCHK;
            end
            wbs_pkg::ST_F_KCHK: begin
                n_state = (r_k < r_i) ? wbs_pkg::ST_F_K0 : wbs_pkg::ST_F_END;
            end
            wbs_pkg::ST_F_K0: begin
                band_raddr = f_baddr(r_k, '0);
                n_state = wbs_pkg::ST_F_K1;
            end
            wbs_pkg::ST_F_K1: begin
                n_d = band_rdata;
                band_raddr = f_baddr(r_k, r_i - r_k);
                n_state = wbs_pkg::ST_F_K2;
            end
            wbs_pkg::ST_F_K2: begin
                n_l1 = band_rdata;
                band_raddr = f_baddr(r_k, r_j - r_k);
                n_state = wbs_pkg::ST_F_K3;
            end
            wbs_pkg::ST_F_K3: begin
                n_l2 = band_rdata;
                mul_start = 1'b1;
                n_state = wbs_pkg::ST_F_K4;
            end
            wbs_pkg::ST_F_K4: begin
                if (mul_done) begin
                    n_d = mul_p;
                    n_state = wbs_pkg::ST_F_K5;
                end
            end
            wbs_pkg::ST_F_K5: begin
                mul_start = 1'b1;
                mul_b = r_l2;
                n_state = wbs_pkg::ST_F_K6;
            end
            wbs_pkg::ST_F_K6: begin
                if (mul_done) begin
                    n_t = f_sat_sub(r_t, mul_p);
                    n_k = r_k + ONE;
                    n_state = wbs_pkg::ST_F_KCHK;
                end
            end
            wbs_pkg::ST_F_END: begin
                if (r_j == r_i) begin
                    band_we = 1'b1;
                    n_s = r_t;
                    if (r_t == '0) begin
                        n_err = 1'b1;
                    end
                    n_state = wbs_pkg::ST_F_JNXT;
                end else begin
                    div_start = 1'b1;
                    n_state = wbs_pkg::ST_F_DIV;
                end
            end
            wbs_pkg::ST_F_DIV: begin
                if (div_done) begin
                    band_we    = 1'b1;
                    band_wdata = div_q;
                    n_state = wbs_pkg::ST_F_JNXT;
                end
            end
            wbs_pkg::ST_F_JNXT: begin
                if (r_j < s_j2) begin
                    n_j = r_j + ONE;
                    n_state = wbs_pkg::ST_F_J;
                end else if (r_i < r_m) begin
                    n_i = r_i + ONE;
                    n_j = r_i + ONE;
                    n_state = wbs_pkg::ST_F_J;
                end else begin
                    n_i = ONE;
                    n_state = wbs_pkg::ST_V_RD;
                end
            end

            // forward solve
            wbs_pkg::ST_V_RD: begin
                n_state = wbs_pkg::ST_V_MUL;
            end
            wbs_pkg::ST_V_MUL: begin
                mul_start = 1'b1;
                mul_a = f_wl(w_rdata, r_inv);
                mul_b = {smp_rdata, {FW{1'b0}}};
                n_state = wbs_pkg::ST_V_MW;
            end
            wbs_pkg::ST_V_MW: begin
                if (mul_done) begin
                    n_s = mul_p;
                    n_j = s_vj1;
                    n_state = wbs_pkg::ST_V_CHK;
                end
            end
            wbs_pkg::ST_V_CHK: begin
                if (r_j < r_i) begin
                    n_state = wbs_pkg::ST_V_R;
                end else begin
                    sol_we = 1'b1;
                    if (r_i < r_m) begin
                        n_i = r_i + ONE;
                        n_state = wbs_pkg::ST_V_RD;
                    end else begin
                        n_state = wbs_pkg::ST_K_RD;
                    end
                end
            end
            wbs_pkg::ST_V_R: begin
                sol_raddr  = f_row(r_j);
                band_raddr = f_baddr(r_j, r_i - r_j);
                n_state = wbs_pkg::ST_V_R1;
            end
            wbs_pkg::ST_V_R1: begin
                mul_start = 1'b1;
                mul_a = sol_rdata;
                mul_b = band_rdata;
                n_state = wbs_pkg::ST_V_W;
            end
            wbs_pkg::ST_V_W: begin
                if (mul_done) begin
                    n_s = f_sat_sub(r_s, mul_p);
                    n_j = r_j + ONE;
                    n_state = wbs_pkg::ST_V_CHK;
                end
            end

            // back solve
            wbs_pkg::ST_K_RD: begin
                sol_raddr  = f_row(r_i);
                band_raddr = f_baddr(r_i, '0);
                n_state = wbs_pkg::ST_K_DIV;
            end
            wbs_pkg::ST_K_DIV: begin
                div_start = 1'b1;
                div_n = sol_rdata;
                div_d = band_rdata;
                n_state = wbs_pkg::ST_K_DW;
            end
            wbs_pkg::ST_K_DW: begin
                if (div_done) begin
                    n_s = div_q;
                    n_j = r_i + ONE;
                    n_state = wbs_pkg::ST_K_CHK;
                end
            end
            wbs_pkg::ST_K_CHK: begin
                if (r_j <= s_j2) begin
                    n_state = wbs_pkg::ST_K_R;
                end else begin
                    sol_we = 1'b1;
                    if (r_i == ONE) begin
                        n_i = '0;
                        n_state = wbs_pkg::ST_O_RD;
                    end else begin
                        n_i = r_i - ONE;
                        n_state = wbs_pkg::ST_K_RD;
                    end
                end
            end
            wbs_pkg::ST_K_R: begin
                sol_raddr  = f_row(r_j);
                band_raddr = f_baddr(r_i, r_j - r_i);
                n_state = wbs_pkg::ST_K_R1;
            end
            wbs_pkg::ST_K_R1: begin
                mul_start = 1'b1;
                mul_a = sol_rdata;
                mul_b = band_rdata;
                n_state = wbs_pkg::ST_K_W;
            end
            wbs_pkg::ST_K_W: begin
                if (mul_done) begin
                    n_s = f_sat_sub(r_s, mul_p);
                    n_j = r_j + ONE;
                    n_state = wbs_pkg::ST_K_CHK;
                end
            end

            // readout, index is zero-based here
            wbs_pkg::ST_O_RD: begin
                sol_raddr = r_i[AW-1:0];
                n_state = wbs_pkg::ST_O_OUT;
            end
            wbs_pkg::ST_O_OUT: begin
                o_strobe = 1'b1;
                o_result.smoothed_value = f_out(sol_rdata);
                o_result.position       = PW'(r_i);
                o_result.last_result    = (r_i == r_m - ONE);
                o_result.pivot_error    = r_err;
                if (r_i == r_m - ONE) begin
                    n_cnt = '0;
                    n_state = wbs_pkg::ST_IDLE;
                end else begin
                    n_i = r_i + ONE;
                    n_state = wbs_pkg::ST_O_RD;
                end
            end

            default: n_state = wbs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wbs_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_err   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m  <= n_m;
        r_n  <= n_n;
        r_i  <= n_i;
        r_j  <= n_j;
        r_k  <= n_k;
        r_s  <= n_s;
        r_t  <= n_t;
        r_d  <= n_d;
        r_l1 <= n_l1;
        r_l2 <= n_l2;
    end

endmodule

// ===== rtl/wbs_checker.sv =====
// ============================================================================
// wbs_checker
// Port-level checks on run and readout sequencing of the band smoother.
// ============================================================================
module wbs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input wbs_pkg::t_in_item  i_in,
    input logic               o_strobe,
    input wbs_pkg::t_out_item o_result
);

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result transfer while idle");

    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_in.last_item) |=> busy)
        else $error("last item did not start a run");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last_result) |=> !busy)
        else $error("busy after final result");

    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last_result) |-> ##2
        (o_strobe && o_result.position == 6'($past(o_result.position, 2) + 6'd1)))
        else $error("positions out of order");

endmodule

bind whittaker_band_smoother_top wbs_checker u_wbs_checker (.*);
